// ===== hw/rtl/zsom_pkg.sv =====
// zsom_pkg: widths, constants and inter-stage structs for the z-score outlier mean.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package zsom_pkg;

    // Sensor count and field widths
    localparam int SENSORS   = 3;
    localparam int RW        = 16;               // reading width
    localparam int TW        = 10;               // threshold width, Q2.8
    localparam int CW        = 2;                // kept count width
    localparam int SW        = RW + 2;           // sum of three readings
    localparam int DW        = RW + 2;           // D = 3*r - S
    localparam int MW        = DW - 1;           // |D|
    localparam int SQW       = 2 * MW;           // D^2
    localparam int VW        = SQW + 2;          // sum of D^2, also 3*D^2
    localparam int TSQW      = 2 * TW;           // threshold^2
    localparam int VLOW      = VW / 2;           // low half of V for split product
    localparam int VHIW      = VW - VLOW;        // high half of V
    localparam int PPW       = TSQW + VLOW;      // partial product width
    localparam int FRAC      = 16;               // 65536 scale on the left side
    localparam int RHSW      = TSQW + VW;        // threshold^2 * V
    localparam int KMW       = SW - 1;           // magnitude of the kept sum

    // Divide by three: q = (m * RECIP3) >> RECIP_SH, exact for m < 2^17
    localparam int              RECIP_SH = KMW + 1;
    localparam logic [KMW-1:0]  RECIP3   = KMW'(((1 << RECIP_SH) + 2) / 3);
    localparam int              QPW      = 2 * KMW;

    localparam logic [TW-1:0]   THRESHOLD_RESET = TW'(333);

    typedef logic [SENSORS-1:0][RW-1:0] t_readings;

    // Spread stage output: per-reading left sides and the variance term
    typedef struct packed {
        logic                          valid;
        t_readings                     r;
        logic [SENSORS-1:0][VW-1:0]    lhs;
        logic [VW-1:0]                 v;
        logic [TSQW-1:0]               tsq;
    } t_spread;

    // Test stage output: readings and the rejection mask
    typedef struct packed {
        logic                  valid;
        t_readings             r;
        logic [SENSORS-1:0]    mask;
    } t_verdict;

    // Final result
    typedef struct packed {
        logic                  valid;
        logic [RW-1:0]         mean;
        logic [CW-1:0]         kept;
        logic [SENSORS-1:0]    mask;
        logic                  none;
    } t_result;

endpackage

// ===== hw/rtl/zsom_spread.sv =====
// zsom_spread: stages 1-3, deviations D, their squares and the variance sum V.
// Depends on zsom_pkg.
`timescale 1ns / 1ps

module zsom_spread (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  zsom_pkg::t_readings   i_readings,
    input  logic [zsom_pkg::TW-1:0] i_threshold,
    output zsom_pkg::t_spread     o_spread
);
    import zsom_pkg::*;

    logic                         r_s1_valid;
    t_readings                    r_s1_r;
    logic [SENSORS-1:0][DW-1:0]   r_s1_d;
    logic [TSQW-1:0]              r_s1_tsq;
    logic [SENSORS-1:0][DW-1:0]   n_s1_d;
    logic [SW-1:0]                n_sum;

    logic                         r_s2_valid;
    t_readings                    r_s2_r;
    logic [SENSORS-1:0][SQW-1:0]  r_s2_dsq;
    logic [TSQW-1:0]              r_s2_tsq;
    logic [SENSORS-1:0][SQW-1:0]  n_s2_dsq;
    logic [SENSORS-1:0][DW-1:0]   n_neg_d;
    logic [SENSORS-1:0][MW-1:0]   n_mag;

    t_spread                      r_s3;
    t_spread                      n_s3;

    // Stage 1: sum and deviations 3*r - S
    always_comb begin
        n_sum = '0;
        for (int i = 0; i < SENSORS; i++) begin
            n_sum = n_sum + {{(SW-RW){i_readings[i][RW-1]}}, i_readings[i]};
        end
        for (int i = 0; i < SENSORS; i++) begin
            n_s1_d[i] = {{(DW-RW-1){i_readings[i][RW-1]}}, i_readings[i], 1'b0}
                      + {{(DW-RW){i_readings[i][RW-1]}}, i_readings[i]}
                      - n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_valid;
        end
        r_s1_r   <= i_readings;
        r_s1_d   <= n_s1_d;
        r_s1_tsq <= TSQW'(i_threshold) * TSQW'(i_threshold);
    end

    // Stage 2: square of each |D|
    always_comb begin
        for (int i = 0; i < SENSORS; i++) begin
            n_neg_d[i]  = -r_s1_d[i];
            n_mag[i]    = r_s1_d[i][DW-1] ? n_neg_d[i][MW-1:0] : r_s1_d[i][MW-1:0];
            n_s2_dsq[i] = SQW'(n_mag[i]) * SQW'(n_mag[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
        r_s2_r   <= r_s1_r;
        r_s2_dsq <= n_s2_dsq;
        r_s2_tsq <= r_s1_tsq;
    end

    // Stage 3: V = sum of D^2, left side 3*D^2
    always_comb begin
        n_s3       = '0;
        n_s3.valid = r_s2_valid;
        n_s3.r     = r_s2_r;
        n_s3.tsq   = r_s2_tsq;
        for (int i = 0; i < SENSORS; i++) begin
            n_s3.v      = n_s3.v + VW'(r_s2_dsq[i]);
            n_s3.lhs[i] = VW'({r_s2_dsq[i], 1'b0}) + VW'(r_s2_dsq[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3.valid <= 1'b0;
        end else begin
            r_s3 <= n_s3;
        end
    end

    assign o_spread = r_s3;

endmodule

// ===== hw/rtl/zsom_test.sv =====
// zsom_test: stages 4-5, threshold^2 * V as two partial products, then the
// per-reading rejection compare. Depends on zsom_pkg.
`timescale 1ns / 1ps

module zsom_test (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  zsom_pkg::t_spread   i_spread,
    output zsom_pkg::t_verdict  o_verdict
);
    import zsom_pkg::*;

    logic                         r_s4_valid;
    t_readings                    r_s4_r;
    logic [SENSORS-1:0][VW-1:0]   r_s4_lhs;
    logic [PPW-1:0]               r_s4_plo;
    logic [PPW-1:0]               r_s4_phi;
    logic                         r_s4_vnz;

    logic [RHSW-1:0]              n_rhs;
    logic [RHSW-1:0]              n_lhs_ext [SENSORS];
    t_verdict                     r_s5;
    t_verdict                     n_s5;

    // Stage 4: split multiply, low and high halves of V
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else begin
            r_s4_valid <= i_spread.valid;
        end
        r_s4_r   <= i_spread.r;
        r_s4_lhs <= i_spread.lhs;
        r_s4_plo <= PPW'(i_spread.tsq) * PPW'(i_spread.v[VLOW-1:0]);
        r_s4_phi <= PPW'(i_spread.tsq) * PPW'(i_spread.v[VW-1:VLOW]);
        r_s4_vnz <= (i_spread.v != '0);
    end

    // Stage 5: recombine and compare 3*D^2*65536 against t^2*V
    always_comb begin
        n_rhs      = {{(RHSW-PPW){1'b0}}, r_s4_plo} + {r_s4_phi[RHSW-VLOW-1:0], {VLOW{1'b0}}};
        n_s5       = '0;
        n_s5.valid = r_s4_valid;
        n_s5.r     = r_s4_r;
        for (int i = 0; i < SENSORS; i++) begin
            n_lhs_ext[i] = {{(RHSW-VW-FRAC){1'b0}}, r_s4_lhs[i], {FRAC{1'b0}}};
            // zero spread keeps everything
            n_s5.mask[i] = r_s4_vnz && (n_lhs_ext[i] > n_rhs);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5.valid <= 1'b0;
        end else begin
            r_s5 <= n_s5;
        end
    end

    assign o_verdict = r_s5;

endmodule

// ===== hw/rtl/zsom_mean.sv =====
// zsom_mean: stages 6-8, sum of kept readings, divide by the kept count with
// truncation toward zero, result register. Depends on zsom_pkg.
`timescale 1ns / 1ps

module zsom_mean (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  zsom_pkg::t_verdict  i_verdict,
    output zsom_pkg::t_result   o_result
);
    import zsom_pkg::*;

    logic [SW-1:0]       n_sum;
    logic [SW-1:0]       n_neg_sum;
    logic [CW-1:0]       n_cnt;

    logic                r_s6_valid;
    logic [KMW-1:0]      r_s6_mag;
    logic                r_s6_neg;
    logic [CW-1:0]       r_s6_cnt;
    logic [SENSORS-1:0]  r_s6_mask;

    logic [QPW-1:0]      n_prod;
    logic [RW-1:0]       n_q;

    logic                r_s7_valid;
    logic [RW-1:0]       r_s7_q;
    logic                r_s7_neg;
    logic [CW-1:0]       r_s7_cnt;
    logic [SENSORS-1:0]  r_s7_mask;

    t_result             r_out;

    // Stage 6: kept sum as sign and magnitude, kept count
    always_comb begin
        n_sum = '0;
        n_cnt = '0;
        for (int i = 0; i < SENSORS; i++) begin
            if (!i_verdict.mask[i]) begin
                n_sum = n_sum + {{(SW-RW){i_verdict.r[i][RW-1]}}, i_verdict.r[i]};
                n_cnt = n_cnt + CW'(1);
            end
        end
        n_neg_sum = -n_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_valid <= 1'b0;
        end else begin
            r_s6_valid <= i_verdict.valid;
        end
        r_s6_mag  <= n_sum[SW-1] ? n_neg_sum[KMW-1:0] : n_sum[KMW-1:0];
        r_s6_neg  <= n_sum[SW-1];
        r_s6_cnt  <= n_cnt;
        r_s6_mask <= i_verdict.mask;
    end

    // Stage 7: unsigned quotient; divide by three via reciprocal multiply
    always_comb begin
        n_prod = QPW'(r_s6_mag) * QPW'(RECIP3);
        case (r_s6_cnt)
            2'd3:    n_q = n_prod[RECIP_SH +: RW];
            2'd2:    n_q = r_s6_mag[RW:1];
            2'd1:    n_q = r_s6_mag[RW-1:0];
            default: n_q = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s7_valid <= 1'b0;
        end else begin
            r_s7_valid <= r_s6_valid;
        end
        r_s7_q    <= n_q;
        r_s7_neg  <= r_s6_neg;
        r_s7_cnt  <= r_s6_cnt;
        r_s7_mask <= r_s6_mask;
    end

    // Stage 8: restore sign, result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid <= 1'b0;
        end else begin
            r_out.valid <= r_s7_valid;
            r_out.mean  <= r_s7_neg ? -r_s7_q : r_s7_q;
            r_out.kept  <= r_s7_cnt;
            r_out.mask  <= r_s7_mask;
            r_out.none  <= (r_s7_cnt == '0);
        end
    end

    assign o_result = r_out;

endmodule

// ===== hw/rtl/z_score_outlier_mean.sv =====
// z_score_outlier_mean: top level, threshold register and the three pipeline parts.
// Depends on zsom_pkg, zsom_spread, zsom_test, zsom_mean.
//
// Usage:
//   Request channel: drive i_reading_a/b/c and pulse start. A request is
//   taken at every rising edge with start high and busy low; busy is held
//   low, so one request can be issued every cycle.
//   Result channel: o_valid is high for exactly one cycle with
//   o_filtered_mean, o_kept_count, o_rejected_mask and o_none_kept. The
//   receiver cannot stall; results come out in request order.
//   The result is registered through the spread, test and mean parts
//   in turn. Throughput: one request per cycle. The depth is set by the
//   squaring stage, the threshold^2 * V product split into two 20x18
//   partial products, the wide compare and the reciprocal divide by three.
//   Config channel: i_cfg_valid / o_cfg_ready with i_cfg_data writes the
//   Q2.8 threshold; ready is always high. Write only while no request is
//   in flight.
//   Reset (i_rst_n low, synchronous): flushes all stage valid bits and
//   loads the threshold with 333 (about 1.3).
`timescale 1ns / 1ps

module z_score_outlier_mean (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [zsom_pkg::RW-1:0] i_reading_a,
    input  logic signed [zsom_pkg::RW-1:0] i_reading_b,
    input  logic signed [zsom_pkg::RW-1:0] i_reading_c,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [zsom_pkg::TW-1:0]        i_cfg_data,
    output logic                          o_valid,
    output logic signed [zsom_pkg::RW-1:0] o_filtered_mean,
    output logic [zsom_pkg::CW-1:0]        o_kept_count,
    output logic [zsom_pkg::SENSORS-1:0]   o_rejected_mask,
    output logic                          o_none_kept
);
    import zsom_pkg::*;

    logic [TW-1:0]  r_threshold;
    t_readings      w_readings;
    t_spread        w_spread;
    t_verdict       w_verdict;
    t_result        w_result;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // Threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_threshold <= i_cfg_data;
        end
    end

    assign w_readings[0] = i_reading_a;
    assign w_readings[1] = i_reading_b;
    assign w_readings[2] = i_reading_c;

    zsom_spread u_spread (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (start && !busy),
        .i_readings  (w_readings),
        .i_threshold (r_threshold),
        .o_spread    (w_spread)
    );

    zsom_test u_test (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_spread  (w_spread),
        .o_verdict (w_verdict)
    );

    zsom_mean u_mean (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_verdict (w_verdict),
        .o_result  (w_result)
    );

    // Result ports
    assign o_valid         = w_result.valid;
    assign o_filtered_mean = w_result.mean;
    assign o_kept_count    = w_result.kept;
    assign o_rejected_mask = w_result.mask;
    assign o_none_kept     = w_result.none;

    // Every request yields a result on o_valid
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##8 o_valid)
        else $error("result missing eight cycles after request");

    // Kept count and rejected mask account for all three readings
    a_count_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($countones(o_rejected_mask) + o_kept_count == SENSORS))
        else $error("kept count disagrees with rejected mask");

    // No-kept flag matches the count and forces a zero mean
    a_none_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_none_kept == (o_kept_count == '0))
                     && (!o_none_kept || o_filtered_mean == '0)))
        else $error("none_kept flag inconsistent");

    // No result without an earlier request
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 8))
        else $error("result without a request");

endmodule
